// ===== rtl/core/csvft_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Byte codes, event codes, register indexes and default sizes shared by the
// tokenizer core and its checker.
// ----------------------------------------------------------------------------
package csvft_pkg;

  // Default counter widths.
  localparam int unsigned LenBitsDef   = 16;
  localparam int unsigned FieldBitsDef = 8;
  localparam int unsigned LineBitsDef  = 16;

  // Special byte values.
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChDq = 8'h22;
  localparam logic [7:0] ChSq = 8'h27;
  localparam logic [7:0] ChBs = 8'h5C;

  // Register reset values.
  localparam logic [7:0] DelimRst    = 8'd44;
  localparam logic       SkipEmptyRst = 1'b0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_DELIMITER  = 1'b0,
    REG_SKIP_EMPTY = 1'b1
  } csvft_reg_e;

  // Event reported with each byte.
  typedef enum logic [2:0] {
    EV_CONTENT  = 3'd0,
    EV_DELIM    = 3'd1,
    EV_LINE_END = 3'd2,
    EV_ABSORB   = 3'd3,
    EV_END_DATA = 3'd4
  } csvft_event_e;

endpackage

// ===== rtl/core/csv_field_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer core
// Follows the field and line structure of a CSV byte stream, one byte a cycle while not stalled.
// ----------------------------------------------------------------------------
// The core takes one text byte per request and returns exactly one result per
// byte, in order. It sustains one byte every clock cycle while not stalled,
// and registers each result. The whole per-byte update (quote tracking,
// escape handling, newline absorption and the saturating length, field and
// line counters) is a single combinational step from the state registers, so
// the state feedback loop is what sets the rate. A two-entry output (result
// register plus skid register) lets the input keep flowing while a result
// waits on a stalled consumer; the input stalls only once both entries hold
// results. The delimiter and skip_empty_lines registers should be written
// while no byte is in flight. A byte with last set reports the end-of-data
// event and returns all tokenizer state to its reset values.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core
  import csvft_pkg::*;
#(
  parameter int unsigned LEN_BITS   = LenBitsDef,
  parameter int unsigned FIELD_BITS = FieldBitsDef,
  parameter int unsigned LINE_BITS  = LineBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  // Byte input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            byte_value_i,
  input  logic                  last_i,
  // Result output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            event_res_o,
  output logic [LEN_BITS-1:0]   field_length_o,
  output logic [FIELD_BITS-1:0] field_index_o,
  output logic [LINE_BITS-1:0]  line_index_o,
  output logic                  quoted_o
);

  localparam int unsigned ResW = 3 + LEN_BITS + FIELD_BITS + LINE_BITS + 1;
  localparam logic [LEN_BITS-1:0]   LenMax   = '1;
  localparam logic [FIELD_BITS-1:0] FieldMax = '1;
  localparam logic [LINE_BITS-1:0]  LineMax  = '1;

  // Configuration registers.
  logic [7:0] delim_q;
  logic       skip_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q      <= DelimRst;
      skip_empty_q <= SkipEmptyRst;
    end else if (cfg_we_i) begin
      unique case (csvft_reg_e'(cfg_idx_i))
        REG_DELIMITER:  delim_q      <= cfg_data_i;
        REG_SKIP_EMPTY: skip_empty_q <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  // Tokenizer state.
  logic                  in_quote_q, in_quote_d;
  logic                  quote_single_q, quote_single_d;
  logic                  esc_q, esc_d;
  logic                  after_cr_q, after_cr_d;
  logic                  line_start_q, line_start_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [FIELD_BITS-1:0] field_q, field_d;
  logic [LINE_BITS-1:0]  line_q, line_d;

  // Handshake bookkeeping for the result register and the skid register.
  logic            out_valid_q;
  logic            skid_full_q;
  logic [ResW-1:0] out_data_q;
  logic [ResW-1:0] skid_data_q;

  logic in_acc;
  logic out_take;

  assign in_stall_o = skid_full_q;
  assign in_acc     = in_valid_i && !skid_full_q;
  assign out_take   = out_valid_q && !out_stall_i;

  // Per-byte step.
  logic                is_nl;
  logic                is_quote;
  logic [LEN_BITS-1:0] len_inc;
  logic [LEN_BITS-1:0] rep_len;
  csvft_event_e        ev;
  csvft_event_e        ev_out;
  logic [ResW-1:0]     res;

  always_comb begin
    is_nl    = (byte_value_i == ChLf) || (byte_value_i == ChCr);
    is_quote = (byte_value_i == ChDq) || (byte_value_i == ChSq);
    len_inc  = (len_q == LenMax) ? len_q : len_q + 1'b1;

    in_quote_d     = in_quote_q;
    quote_single_d = quote_single_q;
    esc_d          = esc_q;
    after_cr_d     = 1'b0;
    line_start_d   = line_start_q;
    len_d          = len_q;
    field_d        = field_q;
    line_d         = line_q;
    ev             = EV_CONTENT;
    rep_len        = len_inc;

    if (esc_q) begin
      // The byte after a backslash inside quotes is plain content.
      esc_d        = 1'b0;
      line_start_d = 1'b0;
      len_d        = len_inc;
    end else if (is_nl && ((after_cr_q && (byte_value_i == ChLf)) ||
                           (skip_empty_q && line_start_q))) begin
      ev         = EV_ABSORB;
      after_cr_d = (byte_value_i == ChCr);
      rep_len    = '0;
    end else if (is_nl) begin
      // A newline ends field and line even inside quotes.
      ev             = EV_LINE_END;
      rep_len        = len_q;
      len_d          = '0;
      field_d        = '0;
      line_d         = (line_q == LineMax) ? line_q : line_q + 1'b1;
      in_quote_d     = 1'b0;
      quote_single_d = 1'b0;
      line_start_d   = 1'b1;
      after_cr_d     = (byte_value_i == ChCr);
    end else if ((byte_value_i == delim_q) && !in_quote_q) begin
      ev           = EV_DELIM;
      line_start_d = 1'b0;
      rep_len      = len_q;
      len_d        = '0;
      field_d      = (field_q == FieldMax) ? field_q : field_q + 1'b1;
    end else begin
      line_start_d = 1'b0;
      len_d        = len_inc;
      if (is_quote) begin
        // Only the quote character that opened the section closes it.
        if (in_quote_q) begin
          if (quote_single_q == (byte_value_i == ChSq)) begin
            in_quote_d = 1'b0;
          end
        end else begin
          in_quote_d     = 1'b1;
          quote_single_d = (byte_value_i == ChSq);
        end
      end else if ((byte_value_i == ChBs) && in_quote_q) begin
        esc_d = 1'b1;
      end
    end

    ev_out = last_i ? EV_END_DATA : ev;
    res    = {ev_out, rep_len, field_q, line_q, in_quote_d};
  end

  // State update; the final byte of the data returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q     <= 1'b0;
      quote_single_q <= 1'b0;
      esc_q          <= 1'b0;
      after_cr_q     <= 1'b0;
      line_start_q   <= 1'b1;
      len_q          <= '0;
      field_q        <= '0;
      line_q         <= '0;
    end else if (in_acc) begin
      if (last_i) begin
        in_quote_q     <= 1'b0;
        quote_single_q <= 1'b0;
        esc_q          <= 1'b0;
        after_cr_q     <= 1'b0;
        line_start_q   <= 1'b1;
        len_q          <= '0;
        field_q        <= '0;
        line_q         <= '0;
      end else begin
        in_quote_q     <= in_quote_d;
        quote_single_q <= quote_single_d;
        esc_q          <= esc_d;
        after_cr_q     <= after_cr_d;
        line_start_q   <= line_start_d;
        len_q          <= len_d;
        field_q        <= field_d;
        line_q         <= line_d;
      end
    end
  end

  // Output control: the skid register catches a result that arrives while the
  // result register is full and stalled, and drains into it first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (out_take) begin
        skid_full_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_full_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (out_take) begin
        out_data_q <= skid_data_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_data_q <= res;
      end else begin
        out_data_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign {event_res_o, field_length_o, field_index_o, line_index_o, quoted_o} = out_data_q;

endmodule

// ===== rtl/core/csvft_checker.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer checker
// Port-level properties of the tokenizer core, attached by a bind statement.
// ----------------------------------------------------------------------------
module csvft_checker
  import csvft_pkg::*;
#(
  parameter int unsigned LEN_BITS   = LenBitsDef,
  parameter int unsigned FIELD_BITS = FieldBitsDef,
  parameter int unsigned LINE_BITS  = LineBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [0:0]            cfg_idx_i,
  input logic [7:0]            cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [7:0]            byte_value_i,
  input logic                  last_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [2:0]            event_res_o,
  input logic [LEN_BITS-1:0]   field_length_o,
  input logic [FIELD_BITS-1:0] field_index_o,
  input logic [LINE_BITS-1:0]  line_index_o,
  input logic                  quoted_o
);

  // A stalled result keeps its place and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) &&
      $stable(field_length_o) && $stable(field_index_o) && $stable(line_index_o) &&
      $stable(quoted_o))
    else $error("stalled result changed");

  // The input only stalls once a result is already waiting at the output.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // An absorbed newline reports an empty field.
  a_absorb_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_ABSORB) |-> (field_length_o == '0))
    else $error("absorbed newline with nonzero length");

  // Field and line ends always leave the stream outside quotes.
  a_end_unquoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((event_res_o == EV_DELIM) || (event_res_o == EV_LINE_END))
      |-> !quoted_o)
    else $error("field end reported inside quotes");

  // A content byte always adds to the field length.
  a_content_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_CONTENT) |-> (field_length_o != '0))
    else $error("content byte with zero length");

endmodule

bind csv_field_tokenizer_core csvft_checker #(
  .LEN_BITS  (LEN_BITS),
  .FIELD_BITS(FIELD_BITS),
  .LINE_BITS (LINE_BITS)
) u_csvft_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer core testbench
// Drives byte requests into the tokenizer under random back-pressure and
// checks every result against a cycle-free model of the tokenizer state.
// ----------------------------------------------------------------------------
// The run has three parts. A short directed script walks the quoting, escape,
// newline-absorption and end-of-data rules, with a few expected results typed
// in by hand. Eight random phases follow, each with its own delimiter and
// empty-line setting, feeding mostly well-formed CSV text with some noise. A
// last phase pushes a long run of delimiters so that the field counter
// reaches saturation.
// ----------------------------------------------------------------------------
module tb;
  import csvft_pkg::*;

  localparam int HoldCycles = 60;
  localparam int TimeLimit  = 1_500_000;
  localparam int PrintCap   = 100;

  // One result as the core reports it.
  typedef struct packed {
    csvft_event_e                 ev;
    logic [LenBitsDef-1:0]   flen;
    logic [FieldBitsDef-1:0] fidx;
    logic [LineBitsDef-1:0]  lidx;
    logic                    quoted;
  } token_t;

  // A directed script row either offers one byte request or rewrites both
  // registers. For a register row, val is the delimiter and flag is the
  // empty-line setting; for a byte row, flag marks the last byte of the data.
  typedef enum logic {
    ROW_BYTE,
    ROW_REGS
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] val;
    logic       flag;
    logic       typed;
    token_t     want;
  } script_row_t;

  localparam token_t NoWant = '{EV_CONTENT, 16'd0, 8'd0, 16'd0, 1'b0};

  localparam script_row_t Script [28] = '{
    // Reset settings: comma delimiter, empty lines counted.
    '{ROW_BYTE, 8'h61,    1'b0, 1'b1, '{EV_CONTENT, 16'd1, 8'd0, 16'd0, 1'b0}},
    '{ROW_BYTE, DelimRst, 1'b0, 1'b1, '{EV_DELIM, 16'd1, 8'd0, 16'd0, 1'b0}},
    '{ROW_BYTE, ChDq,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, DelimRst, 1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChBs,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChDq,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChDq,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChCr,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChLf,     1'b0, 1'b1, '{EV_ABSORB, 16'd0, 8'd0, 16'd1, 1'b0}},
    '{ROW_BYTE, ChSq,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChBs,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChLf,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChCr,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, 8'h00,    1'b0, 1'b0, NoWant},
    '{ROW_BYTE, 8'hFF,    1'b1, 1'b1, '{EV_END_DATA, 16'd2, 8'd0, 16'd2, 1'b0}},
    // The double quote doubles as delimiter; empty lines are skipped.
    '{ROW_REGS, ChDq,     1'b1, 1'b0, NoWant},
    '{ROW_BYTE, ChLf,     1'b0, 1'b1, '{EV_ABSORB, 16'd0, 8'd0, 16'd0, 1'b0}},
    '{ROW_BYTE, ChCr,     1'b0, 1'b1, '{EV_ABSORB, 16'd0, 8'd0, 16'd0, 1'b0}},
    '{ROW_BYTE, ChLf,     1'b0, 1'b1, '{EV_ABSORB, 16'd0, 8'd0, 16'd0, 1'b0}},
    '{ROW_BYTE, ChDq,     1'b0, 1'b1, '{EV_DELIM, 16'd0, 8'd0, 16'd0, 1'b0}},
    '{ROW_BYTE, ChSq,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChDq,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChCr,     1'b1, 1'b0, NoWant},
    // A CR delimiter must still act as a line end.
    '{ROW_REGS, ChCr,     1'b0, 1'b0, NoWant},
    '{ROW_BYTE, ChCr,     1'b0, 1'b1, '{EV_LINE_END, 16'd0, 8'd0, 16'd0, 1'b0}},
    // Top byte value as delimiter.
    '{ROW_REGS, 8'hFF,    1'b1, 1'b0, NoWant},
    '{ROW_BYTE, 8'hFF,    1'b0, 1'b1, '{EV_DELIM, 16'd0, 8'd0, 16'd1, 1'b0}},
    '{ROW_BYTE, ChLf,     1'b1, 1'b1, '{EV_END_DATA, 16'd0, 8'd1, 16'd1, 1'b0}}
  };

  // Delimiters of the random phases; even phases count empty lines, odd
  // phases skip them.
  localparam logic [7:0] PhaseDelims [8] = '{
    DelimRst, 8'h3B, 8'h00, 8'hFF, ChDq, ChBs, ChLf, 8'h09
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  csvft_reg_e cfg_idx   = REG_DELIMITER;
  logic [7:0] cfg_data  = 8'd0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] byte_val  = 8'd0;
  logic       byte_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] ev_res;
  logic [LenBitsDef-1:0]   fld_len;
  logic [FieldBitsDef-1:0] fld_idx;
  logic [LineBitsDef-1:0]  ln_idx;
  logic       quoted;

  csv_field_tokenizer_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .byte_value_i   (byte_val),
    .last_i         (byte_last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_res_o    (ev_res),
    .field_length_o (fld_len),
    .field_index_o  (fld_idx),
    .line_index_o   (ln_idx),
    .quoted_o       (quoted)
  );

  // Model copy of the register settings and of the tokenizer state.
  logic [7:0] cfg_delim = DelimRst;
  logic       cfg_skip  = SkipEmptyRst;

  logic                    q_open;
  logic                    q_single;
  logic                    esc_next;
  logic                    saw_cr;
  logic                    line_fresh;
  logic [LenBitsDef-1:0]   len_cnt;
  logic [FieldBitsDef-1:0] fld_cnt;
  logic [LineBitsDef-1:0]  line_cnt;

  token_t     expected_tokens[$];
  logic [7:0] text_q[$];

  int errors       = 0;
  int results_seen = 0;

  // Idle controls shared by the sender and the receiver. With quiet set,
  // neither side idles; with rush set, only the sender goes flat out.
  bit quiet    = 1'b0;
  bit rush     = 1'b0;
  int hold_len = 0;

  initial forever #1 clk = ~clk;

  initial begin
    #TimeLimit;
    $display("tb: errors");
    $finish;
  end

  function automatic void restart_tracking();
    q_open     = 1'b0;
    q_single   = 1'b0;
    esc_next   = 1'b0;
    saw_cr     = 1'b0;
    line_fresh = 1'b1;
    len_cnt    = '0;
    fld_cnt    = '0;
    line_cnt   = '0;
  endfunction

  // Advances the tokenizer state by one byte and returns what the core
  // should report for it. Field and line indices always report the values
  // held before the byte, so they are taken first.
  function automatic token_t tokenize_byte(input logic [7:0] b, input logic fin);
    token_t t;
    logic   was_cr;
    logic   is_nl;
    was_cr   = saw_cr;
    is_nl    = (b == ChLf) || (b == ChCr);
    saw_cr   = 1'b0;
    t.ev     = EV_CONTENT;
    t.fidx   = fld_cnt;
    t.lidx   = line_cnt;
    if (esc_next) begin
      // The byte after a backslash in quotes is plain content.
      esc_next   = 1'b0;
      line_fresh = 1'b0;
      if (~&len_cnt) len_cnt = len_cnt + 1'b1;
      t.flen = len_cnt;
    end else if (is_nl && ((was_cr && b == ChLf) || (cfg_skip && line_fresh))) begin
      t.ev   = EV_ABSORB;
      saw_cr = (b == ChCr);
      t.flen = '0;
    end else if (is_nl) begin
      t.ev       = EV_LINE_END;
      t.flen     = len_cnt;
      len_cnt    = '0;
      fld_cnt    = '0;
      if (~&line_cnt) line_cnt = line_cnt + 1'b1;
      q_open     = 1'b0;
      q_single   = 1'b0;
      line_fresh = 1'b1;
      saw_cr     = (b == ChCr);
    end else if (b == cfg_delim && !q_open) begin
      t.ev       = EV_DELIM;
      line_fresh = 1'b0;
      t.flen     = len_cnt;
      len_cnt    = '0;
      if (~&fld_cnt) fld_cnt = fld_cnt + 1'b1;
    end else begin
      line_fresh = 1'b0;
      if (b == ChDq || b == ChSq) begin
        // Only the quote that opened a section closes it.
        if (!q_open) begin
          q_open   = 1'b1;
          q_single = (b == ChSq);
        end else if (q_single == (b == ChSq)) begin
          q_open = 1'b0;
        end
      end else if (b == ChBs && q_open) begin
        esc_next = 1'b1;
      end
      if (~&len_cnt) len_cnt = len_cnt + 1'b1;
      t.flen = len_cnt;
    end
    t.quoted = q_open;
    if (fin) begin
      t.ev = EV_END_DATA;
      restart_tracking();
    end
    return t;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (errors < PrintCap) begin
      $display("mismatch in %s at result %0d: got %0h, want %0h",
               what, results_seen, got, want);
    end
    errors++;
  endtask

  // Offers one byte request after a random gap and waits until the core
  // takes it. Valid stays high on return, so a following request with no gap
  // goes out on the very next edge.
  task automatic offer_byte(input logic [7:0] b, input logic fin, input logic typed,
                            input token_t given);
    int     gap;
    token_t pred;
    gap = (quiet || rush) ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    byte_val  <= b;
    byte_last <= fin;
    do @(posedge clk); while (in_stall);
    pred = tokenize_byte(b, fin);
    expected_tokens.push_back(typed ? given : pred);
  endtask

  // Drops valid and waits until every outstanding result has been checked.
  // Each byte yields exactly one result, so the core is idle afterwards.
  task automatic drain_tokens();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  // Writes the delimiter register, then the skip-empty register. Only called while idle.
  task automatic set_dialect(input logic [7:0] delim, input logic skip);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DELIMITER;
    cfg_data  <= delim;
    cfg_delim  = delim;
    @(posedge clk);
    cfg_idx   <= REG_SKIP_EMPTY;
    cfg_data  <= {7'd0, skip};
    cfg_skip   = skip;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Builds a stretch of CSV text: plain and quoted fields, escapes, mixed
  // line endings including blank lines, plus some raw noise and the odd
  // unterminated quote.
  task automatic compose_csv(input int target, input logic [7:0] delim);
    int         kind;
    int         n;
    logic [7:0] q;
    text_q.delete();
    while (text_q.size() < target) begin
      kind = int'($urandom_range(0, 11));
      if (kind == 0) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind <= 2) begin
        n = int'($urandom_range(1, 3));
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: text_q.push_back(ChLf);
            1: text_q.push_back(ChCr);
            default: begin
              text_q.push_back(ChCr);
              text_q.push_back(ChLf);
            end
          endcase
        end
      end else if (kind <= 5) begin
        q = ($urandom_range(0, 1) != 0) ? ChDq : ChSq;
        text_q.push_back(q);
        n = int'($urandom_range(0, 6));
        repeat (n) begin
          case ($urandom_range(0, 7))
            0: begin
              text_q.push_back(ChBs);
              text_q.push_back(8'($urandom_range(0, 255)));
            end
            1: text_q.push_back((q == ChDq) ? ChSq : ChDq);
            2: text_q.push_back(delim);
            default: text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
          endcase
        end
        if ($urandom_range(0, 7) != 0) text_q.push_back(q);
        text_q.push_back(delim);
      end else begin
        n = int'($urandom_range(0, 5));
        repeat (n) text_q.push_back(8'($urandom_range(8'h30, 8'h7A)));
        text_q.push_back(delim);
      end
    end
  endtask

  // Result checker: every accepted result is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        flag_mismatch("unexpected result", 32'(ev_res), 32'd0);
      end else begin
        want = expected_tokens.pop_front();
        if (ev_res !== want.ev) flag_mismatch("event", 32'(ev_res), 32'(want.ev));
        if (fld_len !== want.flen) flag_mismatch("field length", 32'(fld_len), 32'(want.flen));
        if (fld_idx !== want.fidx) flag_mismatch("field index", 32'(fld_idx), 32'(want.fidx));
        if (ln_idx !== want.lidx) flag_mismatch("line index", 32'(ln_idx), 32'(want.lidx));
        if (quoted !== want.quoted) flag_mismatch("quoted", 32'(quoted), 32'(want.quoted));
      end
      results_seen++;
    end
  end

  // Receiver: before each result it stalls for a random number of cycles.
  // A pending hold request replaces that draw with one long stall, during
  // which the core's two result slots fill and its input backs up.
  initial begin
    int n;
    wait (rst_n);
    forever begin
      n = quiet ? 0 : int'($urandom_range(0, 3));
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Sender and overall sequencing.
  initial begin
    restart_tracking();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script; registers keep their reset values until the first
    // register row.
    for (int i = 0; i < $size(Script); i++) begin
      if (Script[i].kind == ROW_REGS) begin
        drain_tokens();
        set_dialect(Script[i].val, Script[i].flag);
      end else begin
        offer_byte(Script[i].val, Script[i].flag, Script[i].typed, Script[i].want);
      end
    end
    drain_tokens();

    // Random phases. Phase 1 holds the receiver off while the sender keeps
    // pushing; every third phase runs with no idling at all.
    for (int ph = 0; ph < 8; ph++) begin
      set_dialect(PhaseDelims[ph], 1'(ph % 2));
      quiet = (ph % 3 == 2);
      if (ph == 1) begin
        rush     = 1'b1;
        hold_len = HoldCycles;
      end
      compose_csv(40, PhaseDelims[ph]);
      foreach (text_q[i]) begin
        offer_byte(text_q[i], (i == text_q.size() - 1) || ($urandom_range(0, 49) == 0),
                   1'b0, NoWant);
      end
      rush  = 1'b0;
      quiet = 1'b0;
      drain_tokens();
    end

    // Field counter saturation: more delimiters than the field counter can
    // count. Both sides run without idling here.
    set_dialect(DelimRst, 1'b0);
    quiet = 1'b1;
    repeat (260) offer_byte(DelimRst, 1'b0, 1'b0, NoWant);
    offer_byte(8'h78, 1'b1, 1'b0, NoWant);
    quiet = 1'b0;
    drain_tokens();

    // Leave a few cycles for any stray result to show up.
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
